[rtl/drcf_pkg.sv]
package drcf_pkg;

   localparam int MAX_RULES = 16;
   localparam int MAX_PORTS = 4;

   localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int RULE_CNT_W = $clog2(MAX_RULES + 1);
   localparam int PORT_IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int PORT_CNT_W = $clog2(MAX_PORTS + 1);

   localparam int PROTO_W  = 4;
   localparam int ADDR_W   = 32;
   localparam int PREFIX_W = 6;
   localparam int PORT_W   = 16;

   localparam logic [PROTO_W-1:0] PROTO_ALL = '0;

   localparam logic [7:0] CLASS_A_LAST = 8'd127;
   localparam logic [7:0] CLASS_B_LAST = 8'd191;
   localparam logic [7:0] CLASS_C_LAST = 8'd223;

   localparam logic [ADDR_W-1:0] CLASS_A_MASK = 32'hFF00_0000;
   localparam logic [ADDR_W-1:0] CLASS_B_MASK = 32'hFFFF_0000;
   localparam logic [ADDR_W-1:0] CLASS_C_MASK = 32'hFFFF_FF00;

   localparam logic [PREFIX_W-1:0] CLASS_A_PREFIX = 6'd8;
   localparam logic [PREFIX_W-1:0] CLASS_B_PREFIX = 6'd16;
   localparam logic [PREFIX_W-1:0] CLASS_C_PREFIX = 6'd24;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_ADD   = 2'd2,
      CMD_CHECK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TABLE_FULL = 2'd1,
      STATUS_PORTS_FULL = 2'd2,
      STATUS_NO_RULE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [PROTO_W-1:0]    protocol;
      logic [ADDR_W-1:0]     network;
      logic [PREFIX_W-1:0]   prefix_len;
      logic [PORT_CNT_W-1:0] port_count;
   } rule_type;

   typedef struct packed {
      logic [PORT_W-1:0] range_start;
      logic [PORT_W-1:0] range_end;
   } range_type;

   typedef range_type [MAX_PORTS-1:0] range_row_type;

   typedef struct packed {
      logic [PROTO_W-1:0] protocol;
      logic [ADDR_W-1:0]  address;
      logic [PORT_W-1:0]  port;
   } check_type;

endpackage

[rtl/drcf_ifs.sv]
interface drcf_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       cmd;
   logic [drcf_pkg::PROTO_W-1:0]     protocol;
   logic [drcf_pkg::ADDR_W-1:0]      address;
   logic [drcf_pkg::PREFIX_W-1:0]    prefix_len;
   logic [drcf_pkg::PORT_W-1:0]      port_low;
   logic [drcf_pkg::PORT_W-1:0]      port_high;

   modport source (output valid, cmd, protocol, address, prefix_len, port_low, port_high,
                   input ready);
   modport sink   (input valid, cmd, protocol, address, prefix_len, port_low, port_high,
                   output ready);
endinterface

interface drcf_rsp_if;
   logic       valid;
   logic       ready;
   logic       deny;
   logic [1:0] status;

   modport source (output valid, deny, status, input ready);
   modport sink   (input valid, deny, status, output ready);
endinterface

[rtl/deny_rule_connection_filter_top.sv]
// Connection deny filter. Commands clear the rule table, open a rule, add a port range
// to the newest rule, or check a connection against all rules. A check walks the rule
// table one rule per cycle through a single registered read of the rule and port-range
// memories and one shared match unit. One command is in flight at a time; the response
// register lets a new command start while the last response is still waiting to be
// taken.
module deny_rule_connection_filter_top (
   input  logic             clock,
   input  logic             reset,
   drcf_req_if.sink         req_chan,
   drcf_rsp_if.source       rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [drcf_pkg::PROTO_W-1:0]  protocol;
      logic [drcf_pkg::ADDR_W-1:0]   address;
      logic [drcf_pkg::PORT_W-1:0]   port_low;
      logic [drcf_pkg::PORT_W-1:0]   port_high;
   } req_type;

   state_type                          state_ff;
   req_type                            req_ff;
   logic [drcf_pkg::RULE_CNT_W-1:0]    rule_count_ff;
   logic [drcf_pkg::RULE_CNT_W-1:0]    walk_ff;
   logic                               vld_ff;
   logic                               deny_ff;
   drcf_pkg::status_type               status_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_deny_ff;
   drcf_pkg::status_type               rsp_status_ff;

   drcf_pkg::rule_type                 rule_mem [drcf_pkg::MAX_RULES];
   drcf_pkg::range_row_type            rng_mem  [drcf_pkg::MAX_RULES];
   drcf_pkg::rule_type                 rule_rd_ff;
   drcf_pkg::range_row_type            rng_rd_ff;

   logic [drcf_pkg::RULE_CNT_W-1:0]    last_rule;
   logic [drcf_pkg::RULE_IDX_W-1:0]    rd_idx;
   logic                               rule_we;
   logic [drcf_pkg::RULE_IDX_W-1:0]    rule_wr_idx;
   drcf_pkg::rule_type                 rule_wr_in;
   logic                               rng_we;
   logic [drcf_pkg::PORT_IDX_W-1:0]    slot;
   logic                               accept;
   logic                               issuing;
   logic                               ports_full;
   logic                               rsp_load;
   logic                               hit;
   drcf_pkg::check_type                chk;

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.deny   = rsp_deny_ff;
   assign rsp_chan.status = rsp_status_ff;

   assign last_rule  = rule_count_ff - drcf_pkg::RULE_CNT_W'(1);
   assign issuing    = (walk_ff < rule_count_ff);
   assign slot       = rule_rd_ff.port_count[drcf_pkg::PORT_IDX_W-1:0];
   assign ports_full = (rule_rd_ff.port_count >= drcf_pkg::PORT_CNT_W'(drcf_pkg::MAX_PORTS));
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign chk.protocol = req_ff.protocol;
   assign chk.address  = req_ff.address;
   assign chk.port     = req_ff.port_low;

   always_comb begin
      rd_idx = last_rule[drcf_pkg::RULE_IDX_W-1:0];
      if (state_ff == S_WALK) begin
         rd_idx = walk_ff[drcf_pkg::RULE_IDX_W-1:0];
      end
   end

   always_comb begin
      rule_we     = 1'b0;
      rng_we      = 1'b0;
      rule_wr_idx = rule_count_ff[drcf_pkg::RULE_IDX_W-1:0];
      rule_wr_in  = rule_rd_ff;
      if (accept && (drcf_pkg::cmd_type'(req_chan.cmd) == drcf_pkg::CMD_OPEN) &&
          (rule_count_ff != drcf_pkg::RULE_CNT_W'(drcf_pkg::MAX_RULES))) begin
         rule_we               = 1'b1;
         rule_wr_in.protocol   = req_chan.protocol;
         rule_wr_in.network    = req_chan.address;
         rule_wr_in.prefix_len = req_chan.prefix_len;
         rule_wr_in.port_count = '0;
      end else if ((state_ff == S_ADD) && !ports_full) begin
         rule_we               = 1'b1;
         rng_we                = 1'b1;
         rule_wr_idx           = last_rule[drcf_pkg::RULE_IDX_W-1:0];
         rule_wr_in.port_count = rule_rd_ff.port_count + drcf_pkg::PORT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[rule_wr_idx] <= rule_wr_in;
      end
      if (rng_we) begin
         rng_mem[rule_wr_idx][slot] <= {req_ff.port_low, req_ff.port_high};
      end
      rule_rd_ff <= rule_mem[rd_idx];
      rng_rd_ff  <= rng_mem[rd_idx];
   end

   drcf_match u_match (
      .rule   (rule_rd_ff),
      .ranges (rng_rd_ff),
      .chk    (chk),
      .hit    (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rule_count_ff <= '0;
         walk_ff       <= '0;
         vld_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff.protocol  <= req_chan.protocol;
                  req_ff.address   <= req_chan.address;
                  req_ff.port_low  <= req_chan.port_low;
                  req_ff.port_high <= req_chan.port_high;
                  deny_ff          <= 1'b0;
                  status_ff        <= drcf_pkg::STATUS_OK;
                  walk_ff          <= '0;
                  vld_ff           <= 1'b0;
                  state_ff         <= S_DONE;
                  unique case (drcf_pkg::cmd_type'(req_chan.cmd))
                     drcf_pkg::CMD_CLEAR: begin
                        rule_count_ff <= '0;
                     end
                     drcf_pkg::CMD_OPEN: begin
                        if (rule_count_ff == drcf_pkg::RULE_CNT_W'(drcf_pkg::MAX_RULES)) begin
                           status_ff <= drcf_pkg::STATUS_TABLE_FULL;
                        end else begin
                           rule_count_ff <= rule_count_ff + drcf_pkg::RULE_CNT_W'(1);
                        end
                     end
                     drcf_pkg::CMD_ADD: begin
                        if (rule_count_ff == '0) begin
                           status_ff <= drcf_pkg::STATUS_NO_RULE;
                        end else begin
                           state_ff <= S_ADD;
                        end
                     end
                     drcf_pkg::CMD_CHECK: begin
                        state_ff <= S_WALK;
                     end
                  endcase
               end
            end
            S_ADD: begin
               if (ports_full) begin
                  status_ff <= drcf_pkg::STATUS_PORTS_FULL;
               end
               state_ff <= S_DONE;
            end
            S_WALK: begin
               vld_ff <= issuing;
               if (issuing) begin
                  walk_ff <= walk_ff + drcf_pkg::RULE_CNT_W'(1);
               end
               if (vld_ff && hit) begin
                  deny_ff <= 1'b1;
               end
               if (!issuing && !vld_ff) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_deny_ff   <= deny_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= drcf_pkg::RULE_CNT_W'(drcf_pkg::MAX_RULES))
      else $error("rule count beyond table size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");

   a_walk_valid: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> state_ff == S_WALK)
      else $error("rule read data valid outside table walk");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd == drcf_pkg::CMD_CLEAR) |=> rule_count_ff == '0)
      else $error("clear left rules in table");

   a_walk_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> walk_ff <= rule_count_ff)
      else $error("table walk ran past last rule");

endmodule

[rtl/drcf_match.sv]
module drcf_match (
   input  drcf_pkg::rule_type      rule,
   input  drcf_pkg::range_row_type ranges,
   input  drcf_pkg::check_type     chk,
   output logic                    hit
);

   logic [7:0]                      octet;
   logic                            have_net;
   logic [drcf_pkg::ADDR_W-1:0]     net;
   logic [drcf_pkg::PREFIX_W-1:0]   plen;
   logic                            proto_hit;
   logic                            port_hit;
   logic                            net_hit;

   assign octet = chk.address[drcf_pkg::ADDR_W-1 -: 8];

   always_comb begin
      have_net = 1'b1;
      net      = chk.address & drcf_pkg::CLASS_A_MASK;
      plen     = drcf_pkg::CLASS_A_PREFIX;
      if (octet <= drcf_pkg::CLASS_A_LAST) begin
         net  = chk.address & drcf_pkg::CLASS_A_MASK;
         plen = drcf_pkg::CLASS_A_PREFIX;
      end else if (octet <= drcf_pkg::CLASS_B_LAST) begin
         net  = chk.address & drcf_pkg::CLASS_B_MASK;
         plen = drcf_pkg::CLASS_B_PREFIX;
      end else if (octet <= drcf_pkg::CLASS_C_LAST) begin
         net  = chk.address & drcf_pkg::CLASS_C_MASK;
         plen = drcf_pkg::CLASS_C_PREFIX;
      end else begin
         have_net = 1'b0;
      end
   end

   always_comb begin
      port_hit = (rule.port_count == '0);
      for (int k = 0; k < drcf_pkg::MAX_PORTS; k++) begin
         if ((drcf_pkg::PORT_CNT_W'(k) < rule.port_count) &&
             (chk.port >= ranges[k].range_start) &&
             (chk.port <= ranges[k].range_end)) begin
            port_hit = 1'b1;
         end
      end
   end

   assign proto_hit = (rule.protocol == drcf_pkg::PROTO_ALL) ||
                      (rule.protocol == chk.protocol);
   assign net_hit   = have_net && (rule.network == net) && (rule.prefix_len == plen);
   assign hit       = proto_hit && port_hit && net_hit;

endmodule
